// ----- rtl/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants for the multi-servo position ramp: the stored
// per-servo entry, item mode codes and the divider request/response bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msr_pkg;

  localparam int POS_W     = 16;
  localparam int IDX_W     = 5;
  localparam int MODE_W    = 2;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_SET  = 2'd2
  } msr_mode_e;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] goal;
    logic [POS_W-1:0] step;
  } msr_entry_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [POS_W-1:0] magnitude;
    logic [POS_W-1:0] divisor;
  } msr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } msr_div_rsp_t;

endpackage

// ----- rtl/msr_ram.sv -----
// ----------------------------------------------------------------------------
// msr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/msr_div.sv -----
// ----------------------------------------------------------------------------
// msr_div
// Iterative restoring divider: one quotient bit per cycle, for a 16-bit quotient.
// Quotient is truncated toward zero and returned in two's complement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msr_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msr_pkg::msr_div_req_t req_i,
  output msr_pkg::msr_div_rsp_t rsp_o
);
  import msr_pkg::*;

  logic [POS_W-1:0]     num_q, num_d;
  logic [POS_W-1:0]     rem_q, rem_d;
  logic [POS_W-1:0]     div_q, div_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [POS_W:0]       rem_shift;
  logic                 ge;

  always_comb begin
    rem_shift = {rem_q, num_q[POS_W-1]};
    ge        = rem_shift >= {1'b0, div_q};
    num_d     = num_q;
    rem_d     = rem_q;
    div_d     = div_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = done_q;
    if (req_i.start) begin
      num_d  = req_i.magnitude;
      rem_d  = '0;
      div_d  = req_i.divisor;
      neg_d  = req_i.neg;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? POS_W'(rem_shift - {1'b0, div_q}) : POS_W'(rem_shift);
      num_d = {num_q[POS_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (POS_W'(0) - num_q) : num_q;

  property p_start_clears_done;
    @(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q && !done_q;
  endproperty
  a_start_clears_done: assert property (p_start_clears_done)
    else $error("divider did not restart");

  property p_busy_done_exclusive;
    @(posedge clk_i) disable iff (!rst_ni) !(busy_q && done_q);
  endproperty
  a_busy_done_exclusive: assert property (p_busy_done_exclusive)
    else $error("divider busy and done together");

  property p_done_after_last;
    @(posedge clk_i) disable iff (!rst_ni)
      busy_q && cnt_q == '0 && !req_i.start |=> done_q;
  endproperty
  a_done_after_last: assert property (p_done_after_last)
    else $error("divider missed completion");

endmodule

// ----- rtl/multi_servo_position_ramp.sv -----
// ----------------------------------------------------------------------------
// multi_servo_position_ramp
// Per-servo position, goal and step kept in one RAM. Move commands start a
// linear ramp (step from an iterative divider) or, if none applies, set the
// position at once; ticks advance it and clamp at the goal; direct sets write it.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_ready_o  mode, servo_index,
//                                                 target_position, move_time
//   out       source     out_valid_o / out_ready_i  position
//
// Tick, set, immediate move: entry read in S_READ, result registered into the output register.
// Ramp start: S_READ starts the 16-step divider; S_DIV registers the result once it is done.
// One item in flight; the next is taken while a result waits in the output
// register. Reset clears per-entry valid bits, so no clearing pass is needed.
// A stalled output holds the finishing item until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_servo_position_ramp #(
  parameter int NUM_SERVOS     = 26,
  parameter int TICK_PERIOD_MS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [msr_pkg::MODE_W-1:0]  mode_i,
  input  logic [msr_pkg::IDX_W-1:0]   servo_index_i,
  input  logic [msr_pkg::POS_W-1:0]   target_position_i,
  input  logic [msr_pkg::POS_W-1:0]   move_time_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [msr_pkg::POS_W-1:0]   position_o
);
  import msr_pkg::*;

  localparam int AddrW     = NUM_SERVOS > 1 ? $clog2(NUM_SERVOS) : 1;
  localparam int TickShift = POS_W + $clog2(TICK_PERIOD_MS);
  localparam longint unsigned TickMul =
    ((64'd1 << TickShift) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;
  localparam int MulW  = 18;
  localparam int ProdW = POS_W + MulW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [AddrW-1:0] addr_q;
  logic             oor_q;
  logic [POS_W-1:0] target_q;
  logic [ProdW-1:0] tick_prod_q;
  logic [POS_W-1:0] pos_q;
  logic [NUM_SERVOS-1:0] valid_q, valid_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] position_q, position_d;

  logic             accept;
  logic             can_out;
  logic             oor_in;
  msr_entry_t       rdata;
  msr_entry_t       entry;
  msr_entry_t       wdata;
  logic             mem_we;
  logic [POS_W-1:0] ticks;
  logic             ramp_ok;
  logic [POS_W-1:0] tick_sum;
  logic             tick_hit;
  msr_div_req_t     div_req;
  msr_div_rsp_t     div_rsp;

  assign accept  = in_valid_i && in_ready_o;
  assign can_out = !out_valid_q || out_ready_i;
  assign oor_in  = {2'b00, servo_index_i} >= 7'(NUM_SERVOS);

  msr_ram #(
    .Width($bits(msr_entry_t)),
    .Depth(NUM_SERVOS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .re_i   (accept),
    .raddr_i(AddrW'(servo_index_i)),
    .rdata_o(rdata)
  );

  msr_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    entry    = valid_q[addr_q] ? rdata : '0;
    ticks    = POS_W'(tick_prod_q >> TickShift);
    ramp_ok  = entry.pos != target_q && entry.pos != '0 && target_q != '0 &&
               ticks != '0;
    tick_sum = entry.pos + entry.step;
    tick_hit = entry.step[POS_W-1] ? (tick_sum <= entry.goal) : (tick_sum >= entry.goal);

    div_req.start     = 1'b0;
    div_req.neg       = target_q < entry.pos;
    div_req.magnitude = div_req.neg ? (entry.pos - target_q) : (target_q - entry.pos);
    div_req.divisor   = ticks;

    state_d     = state_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    position_d  = position_q;
    mem_we      = 1'b0;
    wdata       = entry;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (oor_q) begin
          if (can_out) begin
            out_valid_d = 1'b1;
            position_d  = '0;
            state_d     = S_IDLE;
          end
        end else if (mode_q == MODE_MOVE && ramp_ok) begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end else if (can_out) begin
          out_valid_d = 1'b1;
          position_d  = entry.pos;
          state_d     = S_IDLE;
          case (mode_q) inside
            MODE_MOVE, MODE_SET: begin
              mem_we     = 1'b1;
              wdata      = '{pos: target_q, goal: '0, step: '0};
              position_d = target_q;
            end
            MODE_TICK: begin
              if (entry.step != '0) begin
                mem_we     = 1'b1;
                wdata.pos  = tick_hit ? entry.goal : tick_sum;
                wdata.step = tick_hit ? '0 : entry.step;
                position_d = wdata.pos;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done && can_out) begin
          mem_we      = 1'b1;
          wdata       = '{pos: pos_q, goal: target_q, step: div_rsp.quotient};
          out_valid_d = 1'b1;
          position_d  = pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (mem_we) begin
      valid_d[addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= mode_i;
      addr_q      <= AddrW'(servo_index_i);
      oor_q       <= oor_in;
      target_q    <= target_position_i;
      tick_prod_q <= ProdW'(move_time_i) * ProdW'(MulW'(TickMul));
    end
    if (state_q == S_READ) begin
      pos_q <= entry.pos;
    end
    position_q <= position_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;

  property p_accept_reads;
    @(posedge clk_i) disable iff (!rst_ni) accept |=> state_q == S_READ;
  endproperty
  a_accept_reads: assert property (p_accept_reads)
    else $error("accepted transaction did not enter read");

  property p_write_needs_slot;
    @(posedge clk_i) disable iff (!rst_ni) mem_we |-> can_out;
  endproperty
  a_write_needs_slot: assert property (p_write_needs_slot)
    else $error("entry written while output register blocked");

  property p_write_marks_valid;
    @(posedge clk_i) disable iff (!rst_ni) mem_we |=> valid_q[$past(addr_q)];
  endproperty
  a_write_marks_valid: assert property (p_write_marks_valid)
    else $error("written entry not marked valid");

  property p_oor_no_write;
    @(posedge clk_i) disable iff (!rst_ni) state_q == S_READ && oor_q |-> !mem_we;
  endproperty
  a_oor_no_write: assert property (p_oor_no_write)
    else $error("out-of-range servo wrote state");

endmodule
